// File: hdl/rrtt_pkg.sv
// ----------------------------------------------------------------------------
// rrtt_pkg: shared types and constants for the round-robin task table
// Opcodes, CRC constants and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package rrtt_pkg;

   localparam logic [2:0] OP_SPAWN_CNT = 3'd0;
   localparam logic [2:0] OP_SPAWN_CRC = 3'd1;
   localparam logic [2:0] OP_LOAD      = 3'd2;
   localparam logic [2:0] OP_KILL      = 3'd3;
   localparam logic [2:0] OP_RUN       = 3'd4;
   localparam logic [2:0] OP_QUERY     = 3'd5;

   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
   localparam logic [30:0] PID_MAX   = 31'h7FFFFFFF;
   localparam logic [30:0] PID_FIRST = 31'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [12:0] length;
      logic [11:0] address;
      logic [7:0]  data_byte;
      logic [30:0] target_pid;
      logic [5:0]  index;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [30:0] pid;
      logic        task_type;
      logic        task_state;
      logic [31:0] run_count;
      logic [12:0] bytes_done;
      logic [12:0] total_bytes;
      logic [31:0] crc_value;
      logic [6:0]  active_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;     // capture request word
      logic scan;      // step the scan index
      logic scan_clr;  // restart scan
      logic pid_step;  // advance pid candidate
      logic spawn;     // commit spawn
      logic load;      // write buffer
      logic kill;      // clear matched slot
      logic run_pick;  // select rr slot, bump runs
      logic crc_rd;    // issue buffer read
      logic crc_byte;  // fold read byte into CRC
      logic run_done;  // write back CRC
      logic query;     // report queried slot
      logic fail;      // report refusal
      logic rsp_load;  // drive output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] opcode;
      logic       scan_last;
      logic       spawn_ok;
      logic       pid_clash;
      logic       load_ok;
      logic       kill_hit;
      logic       run_hit;
      logic       run_is_crc;
      logic       crc_more;
      logic       query_hit;
   } sts_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/rrtt_stream_if.sv
// ----------------------------------------------------------------------------
// rrtt_stream_if: valid/ready channel
// Carries one word of payload type T per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrtt_stream_if #(parameter type T = logic) ();
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/rrtt_ram.sv
// ----------------------------------------------------------------------------
// rrtt_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                           wdata,
   output logic      [WIDTH-1:0]                           rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end
endmodule

`default_nettype wire

// File: hdl/rrtt_ctrl.sv
// ----------------------------------------------------------------------------
// rrtt_ctrl: sequencer for the task table
// Walks each request word through decode and, as its opcode needs, pid search, slot scan and CRC phases, then response.
// ----------------------------------------------------------------------------
`default_nettype none

module rrtt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire rrtt_pkg::sts_type sts,
   output rrtt_pkg::cmd_type      cmd
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DEC   = 3'd1;
   localparam logic [2:0] S_PID   = 3'd2;
   localparam logic [2:0] S_RSCAN = 3'd3;
   localparam logic [2:0] S_CRC   = 3'd4;
   localparam logic [2:0] S_CRCW  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.latch = 1'b1;
               state_in  = S_DEC;
            end
         end
         S_DEC: begin
            unique case (sts.opcode)
               rrtt_pkg::OP_SPAWN_CNT, rrtt_pkg::OP_SPAWN_CRC: begin
                  if (sts.spawn_ok) begin
                     cmd.scan_clr = 1'b1;
                     state_in     = S_PID;
                  end else begin
                     cmd.fail = 1'b1;
                     state_in = S_OUT;
                  end
               end
               rrtt_pkg::OP_LOAD: begin
                  if (sts.load_ok) cmd.load = 1'b1;
                  else cmd.fail = 1'b1;
                  state_in = S_OUT;
               end
               rrtt_pkg::OP_KILL: begin
                  if (sts.kill_hit) cmd.kill = 1'b1;
                  else cmd.fail = 1'b1;
                  state_in = S_OUT;
               end
               rrtt_pkg::OP_RUN: begin
                  cmd.scan_clr = 1'b1;
                  state_in     = S_RSCAN;
               end
               rrtt_pkg::OP_QUERY: begin
                  if (sts.query_hit) cmd.query = 1'b1;
                  else cmd.fail = 1'b1;
                  state_in = S_OUT;
               end
               default: begin
                  cmd.fail = 1'b1;
                  state_in = S_OUT;
               end
            endcase
         end
         S_PID: begin
            // one candidate per cycle, checked against all active slots
            if (sts.pid_clash) cmd.pid_step = 1'b1;
            else begin
               cmd.spawn = 1'b1;
               state_in  = S_OUT;
            end
         end
         S_RSCAN: begin
            // one slot per cycle from the round-robin pointer
            if (sts.run_hit) begin
               cmd.run_pick = 1'b1;
               if (sts.run_is_crc) state_in = S_CRC;
               else state_in = S_OUT;
            end else if (sts.scan_last) begin
               cmd.fail = 1'b1;
               state_in = S_OUT;
            end else cmd.scan = 1'b1;
         end
         S_CRC: begin
            if (sts.crc_more) begin
               cmd.crc_rd = 1'b1;
               state_in   = S_CRCW;
            end else begin
               cmd.run_done = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_CRCW: begin
            cmd.crc_byte = 1'b1;
            state_in     = S_CRC;
         end
         S_OUT: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

`default_nettype wire

// File: hdl/rrtt_datapath.sv
// ----------------------------------------------------------------------------
// rrtt_datapath: slot table, pid counter, byte buffer and CRC unit
// Acts on controller commands and reports status flags back.
// ----------------------------------------------------------------------------
`default_nettype none

module rrtt_datapath #(
   parameter int MAX_TASKS    = 8,
   parameter int BUFFER_BYTES = 4096,
   parameter int CHUNK_BYTES  = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rrtt_pkg::req_type req_word,
   input  wire rrtt_pkg::cmd_type cmd,
   output rrtt_pkg::sts_type      sts,
   output rrtt_pkg::rsp_type      rsp_word
);
   localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam int CW = $clog2(CHUNK_BYTES + 1);
   localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_TASKS - 1);

   rrtt_pkg::req_type r_ff;
   rrtt_pkg::rsp_type rsp_ff, rsp_in;

   logic [MAX_TASKS-1:0] act_ff, kind_ff, phase_ff;
   logic [30:0] pid_ff   [MAX_TASKS];
   logic [31:0] runs_ff  [MAX_TASKS];
   logic [12:0] prog_ff  [MAX_TASKS];
   logic [12:0] total_ff [MAX_TASKS];
   logic [31:0] crcs_ff  [MAX_TASKS];
   logic [30:0] pidc_ff;
   logic [SW-1:0] rr_ff, scan_ff, sel_ff;
   logic [31:0] crc_ff;
   logic [12:0] prog_w_ff;
   logic [CW-1:0] chunk_ff;
   logic        fail_ff;
   logic [30:0] spawn_pid_ff;

   logic [SW-1:0] free_idx, kill_idx, q_idx;
   logic free_ok, kill_ok, q_ok, pend;
   logic [6:0] nact;
   logic [30:0] cand;
   logic clash;
   logic [7:0] rd_byte;

   always_comb begin
      free_ok = 1'b0; free_idx = '0; kill_ok = 1'b0; kill_idx = '0;
      q_ok = 1'b0; q_idx = '0; pend = 1'b0; nact = '0; clash = 1'b0;
      cand = (pidc_ff < rrtt_pkg::PID_FIRST) ? rrtt_pkg::PID_FIRST : pidc_ff;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (!act_ff[i] && !free_ok) begin
            free_ok = 1'b1; free_idx = SW'(i);
         end
         if (act_ff[i] && pid_ff[i] == r_ff.target_pid && !kill_ok) begin
            kill_ok = 1'b1; kill_idx = SW'(i);
         end
         if (act_ff[i] && nact == {1'b0, r_ff.index} && !q_ok) begin
            q_ok = 1'b1; q_idx = SW'(i);
         end
         if (act_ff[i] && kind_ff[i] && !phase_ff[i]) pend = 1'b1;
         if (act_ff[i] && pid_ff[i] == cand) clash = 1'b1;
         nact = nact + {6'd0, act_ff[i]};
      end
   end

   // job length never exceeds the buffer, so the progress is a direct address
   logic [AW-1:0] ram_addr;
   assign ram_addr = cmd.load ? AW'(r_ff.address) : AW'(prog_w_ff);

   rrtt_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
      .clock    (clock),
      .we       (cmd.load),
      .addr     (ram_addr),
      .wdata    (r_ff.data_byte),
      .rdata_ff (rd_byte)
   );

   logic [SW-1:0] cur;
   assign cur = scan_ff;

   always_comb begin
      sts.opcode     = r_ff.opcode;
      sts.scan_last  = (sel_ff == LAST_SLOT);
      sts.spawn_ok   = free_ok && !(r_ff.opcode == rrtt_pkg::OP_SPAWN_CRC &&
                       (pend || {19'd0, r_ff.length} > 32'(BUFFER_BYTES)));
      sts.pid_clash  = clash;
      sts.load_ok    = !pend && ({20'd0, r_ff.address} < 32'(BUFFER_BYTES));
      sts.kill_hit   = kill_ok && r_ff.target_pid >= rrtt_pkg::PID_FIRST;
      sts.run_hit    = act_ff[cur] && !phase_ff[cur];
      sts.run_is_crc = kind_ff[cur];
      sts.crc_more   = (chunk_ff != CW'(CHUNK_BYTES)) && (prog_w_ff < total_ff[cur]);
      sts.query_hit  = q_ok;
   end

   function automatic rrtt_pkg::rsp_type report(input logic [30:0] p, input logic k,
         input logic ph, input logic [31:0] rc, input logic [12:0] bd,
         input logic [12:0] tb, input logic [31:0] c);
      rrtt_pkg::rsp_type o;
      o = '0;
      o.pid = p; o.task_type = k; o.task_state = ph; o.run_count = rc;
      o.bytes_done = bd; o.total_bytes = tb; o.crc_value = ph ? c : 32'd0;
      return o;
   endfunction

   logic [31:0] fin_crc;
   logic        fin_done;
   assign fin_done = prog_w_ff >= total_ff[cur];
   assign fin_crc  = fin_done ? ~crc_ff : crc_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) r_ff <= req_word;
      if (cmd.rsp_load) rsp_ff <= rsp_in;
      if (reset) begin
         act_ff <= '0; kind_ff <= '0; phase_ff <= '1; fail_ff <= 1'b0;
         pidc_ff <= rrtt_pkg::PID_FIRST; rr_ff <= '0; scan_ff <= '0; sel_ff <= '0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            pid_ff[i] <= '0; runs_ff[i] <= '0; prog_ff[i] <= '0;
            total_ff[i] <= '0; crcs_ff[i] <= '0;
         end
      end else begin
         if (cmd.latch) fail_ff <= 1'b0;
         if (cmd.fail) fail_ff <= 1'b1;
         if (cmd.scan_clr) begin
            scan_ff <= rr_ff;
            sel_ff  <= '0;
         end
         if (cmd.scan) begin
            scan_ff <= (scan_ff == LAST_SLOT) ? '0 : scan_ff + 1'b1;
            sel_ff  <= sel_ff + 1'b1;
         end
         if (cmd.pid_step) pidc_ff <= (cand + 31'd1) & rrtt_pkg::PID_MAX;
         if (cmd.spawn) begin
            pidc_ff <= (cand + 31'd1) & rrtt_pkg::PID_MAX;
            act_ff[free_idx]   <= 1'b1;
            pid_ff[free_idx]   <= cand;
            kind_ff[free_idx]  <= r_ff.opcode[0];
            phase_ff[free_idx] <= 1'b0;
            runs_ff[free_idx]  <= '0;
            prog_ff[free_idx]  <= '0;
            total_ff[free_idx] <= r_ff.opcode[0] ? r_ff.length : 13'd0;
            crcs_ff[free_idx]  <= rrtt_pkg::CRC_INIT;
         end
         if (cmd.kill) begin
            act_ff[kill_idx] <= 1'b0; pid_ff[kill_idx] <= '0; runs_ff[kill_idx] <= '0;
            prog_ff[kill_idx] <= '0; total_ff[kill_idx] <= '0; crcs_ff[kill_idx] <= '0;
         end
         if (cmd.fail && r_ff.opcode == rrtt_pkg::OP_RUN) scan_ff <= rr_ff;
         if (cmd.run_pick) begin
            rr_ff <= (cur == LAST_SLOT) ? '0 : cur + 1'b1;
            runs_ff[cur] <= runs_ff[cur] + 32'd1;
            crc_ff    <= crcs_ff[cur];
            prog_w_ff <= prog_ff[cur];
            chunk_ff  <= '0;
         end
         if (cmd.crc_byte) begin
            crc_ff    <= rrtt_pkg::crc_byte(crc_ff, rd_byte);
            prog_w_ff <= prog_w_ff + 13'd1;
            chunk_ff  <= chunk_ff + 1'b1;
         end
         if (cmd.run_done) begin
            crcs_ff[cur] <= fin_crc;
            prog_ff[cur] <= prog_w_ff;
            if (fin_done) phase_ff[cur] <= 1'b1;
         end
      end
   end

   // spawn pid is captured at commit
   always_ff @(posedge clock) if (cmd.spawn) spawn_pid_ff <= cand;

   always_comb begin
      rsp_in = '0;
      if (fail_ff)
         rsp_in.status = 1'b1;
      else if (r_ff.opcode == rrtt_pkg::OP_QUERY)
         rsp_in = report(pid_ff[q_idx], kind_ff[q_idx], phase_ff[q_idx], runs_ff[q_idx],
                         prog_ff[q_idx], total_ff[q_idx], crcs_ff[q_idx]);
      else if (r_ff.opcode == rrtt_pkg::OP_RUN)
         rsp_in = report(pid_ff[cur], kind_ff[cur], phase_ff[cur], runs_ff[cur],
                         prog_ff[cur], total_ff[cur], crcs_ff[cur]);
      else if (r_ff.opcode == rrtt_pkg::OP_SPAWN_CNT || r_ff.opcode == rrtt_pkg::OP_SPAWN_CRC)
         rsp_in.pid = spawn_pid_ff;
   end

   always_comb begin
      rsp_word = rsp_ff;
      rsp_word.active_count = nact;
   end
endmodule

`default_nettype wire

// File: hdl/round_robin_task_table_with_crc_jobs_top.sv
// ----------------------------------------------------------------------------
// round_robin_task_table_with_crc_jobs_top: task table with CRC-32 jobs
// Controller plus slot/buffer datapath behind valid/ready channels.
// ----------------------------------------------------------------------------
// One word at a time. A spawn steps its pid candidate past every identifier
// already held by an active slot. A run scans one slot per cycle from the
// round-robin pointer (up to MAX_TASKS slots), and a checksum run then reads
// its bytes one at a time through the single-port buffer RAM, up to
// CHUNK_BYTES bytes per run. A new word is taken once the previous response
// has left.
`default_nettype none

module round_robin_task_table_with_crc_jobs_top #(
   parameter int MAX_TASKS    = 8,
   parameter int BUFFER_BYTES = 4096,
   parameter int CHUNK_BYTES  = 64
) (
   input wire logic clock,
   input wire logic reset,
   rrtt_stream_if.sink   req,
   rrtt_stream_if.source rsp
);
   rrtt_pkg::cmd_type cmd;
   rrtt_pkg::sts_type sts;

   rrtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rrtt_datapath #(
      .MAX_TASKS    (MAX_TASKS),
      .BUFFER_BYTES (BUFFER_BYTES),
      .CHUNK_BYTES  (CHUNK_BYTES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req.data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_word (rsp.data)
   );
endmodule

`default_nettype wire
